// ===== rtl/core/sirt_pkg.sv =====
// Shared types, constants and functions of the signed integer to radix text block.
package sirt_pkg;

	localparam int SLOTS      = 16;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int SLOT_CNT_W = $clog2(SLOTS + 1);
	localparam int SYM_W      = 8;
	localparam int ALPHA_W    = SLOTS * SYM_W;
	localparam int REG_W      = 64;
	localparam int MAG_W      = 32;
	localparam int CHUNK_W    = 8;
	localparam int CHUNKS     = MAG_W / CHUNK_W;
	localparam int CHUNK_CW   = $clog2(CHUNKS);
	localparam int DIGITS_MAX = 32;
	localparam int DIG_IDX_W  = $clog2(DIGITS_MAX);
	localparam int DIG_CNT_W  = $clog2(DIGITS_MAX + 1);
	localparam int CFG_IDX_W  = 1;

	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 1'b1;

	localparam logic [REG_W-1:0] ALPHA_LOW_RST  = 64'h3736353433323130;
	localparam logic [REG_W-1:0] ALPHA_HIGH_RST = 64'h0000000000003938;

	typedef struct packed {
		logic ok;
		logic [SLOT_CNT_W-1:0] len;
	} alpha_chk_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic check;
		logic div_step;
		logic emit_load;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic alpha_ok;
		logic div_last;
		logic quo_zero;
		logic emit_last;
		logic out_free;
	} dp_stat_t;

	function automatic logic [SYM_W-1:0] slot_sym(input logic [ALPHA_W-1:0] a,
	                                              input logic [SLOT_W-1:0] k);
		return a[{k, 3'b000} +: SYM_W];
	endfunction

	// Length is the first zero slot; reject short alphabets, sign symbols and repeats.
	function automatic alpha_chk_t alpha_check(input logic [ALPHA_W-1:0] a);
		alpha_chk_t res;
		logic [SYM_W-1:0] si;
		res.len = SLOT_CNT_W'(SLOTS);
		res.ok  = 1'b1;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (a[i*SYM_W +: SYM_W] == '0) begin
				res.len = SLOT_CNT_W'(i);
			end
		end
		if (res.len < SLOT_CNT_W'(2)) begin
			res.ok = 1'b0;
		end
		for (int i = 0; i < SLOTS; i++) begin
			si = a[i*SYM_W +: SYM_W];
			if (SLOT_CNT_W'(i) < res.len) begin
				if (si == SYM_PLUS || si == SYM_MINUS) begin
					res.ok = 1'b0;
				end
				for (int j = i + 1; j < SLOTS; j++) begin
					if (SLOT_CNT_W'(j) < res.len && a[j*SYM_W +: SYM_W] == si) begin
						res.ok = 1'b0;
					end
				end
			end
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/sirt_ctrl.sv =====
// Controller state machine: sequences accept, alphabet check, division and emission.
module sirt_ctrl import sirt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd.load_in   = 1'b0;
		cmd.check     = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.emit_load = 1'b0;
		in_ready      = 1'b0;
		state_d       = state_q;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = stat.alpha_ok ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last && stat.quo_zero) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit_load = stat.out_free;
				if (stat.out_free && stat.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/sirt_dp.sv =====
// Datapath: alphabet registers, magnitude long division, digit stack and output register.
module sirt_dp import sirt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [REG_W-1:0]      cfg_data,
	input  logic signed [MAG_W-1:0] value,
	input  ctl_cmd_t              cmd,
	output dp_stat_t              stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SYM_W-1:0]      symbol,
	output logic                  last
);

	logic [REG_W-1:0]      alpha_low_q, alpha_high_q;
	logic [ALPHA_W-1:0]    alpha;
	alpha_chk_t            chk;

	logic [MAG_W-1:0]      mag_q, mag_next;
	logic                  neg_q, sign_pend_q;
	logic [SLOT_CNT_W-1:0] radix_q;
	logic [SLOT_CNT_W-1:0] rem_q, rem_next;
	logic [CHUNK_CW-1:0]   chunk_q;
	logic [CHUNK_W-1:0]    qbits;
	logic [SLOT_W-1:0]     digit_q [DIGITS_MAX];
	logic [DIG_CNT_W-1:0]  cnt_q, cnt_m1;
	logic                  out_valid_q, last_q;
	logic [SYM_W-1:0]      symbol_q;
	logic [MAG_W-1:0]      abs_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_low_q  <= ALPHA_LOW_RST;
			alpha_high_q <= ALPHA_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA_LOW:  alpha_low_q  <= cfg_data;
				REG_ALPHA_HIGH: alpha_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign alpha = {alpha_high_q, alpha_low_q};
	assign chk   = alpha_check(alpha);

	// Two's complement of the unsigned word gives 0x80000000 for the most negative input.
	assign abs_in = value[MAG_W-1] ? (~MAG_W'(value) + MAG_W'(1)) : MAG_W'(value);

	// Eight restoring-division steps per cycle; quotient bits shift in at the bottom.
	always_comb begin
		logic [SLOT_CNT_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < CHUNK_W; i++) begin
			r = {r[SLOT_CNT_W-2:0], mag_q[MAG_W-1-i]};
			qbits[CHUNK_W-1-i] = (r >= radix_q);
			if (r >= radix_q) begin
				r = r - radix_q;
			end
		end
		rem_next = r;
		mag_next = {mag_q[MAG_W-CHUNK_W-1:0], qbits};
	end

	assign cnt_m1 = cnt_q - DIG_CNT_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mag_q   <= abs_in;
			neg_q   <= value[MAG_W-1];
			rem_q   <= '0;
			chunk_q <= '0;
			cnt_q   <= '0;
		end
		if (cmd.check) begin
			radix_q     <= chk.len;
			sign_pend_q <= neg_q;
		end
		if (cmd.div_step) begin
			mag_q   <= mag_next;
			chunk_q <= chunk_q + CHUNK_CW'(1);
			if (stat.div_last) begin
				digit_q[cnt_q[DIG_IDX_W-1:0]] <= rem_next[SLOT_W-1:0];
				cnt_q <= cnt_q + DIG_CNT_W'(1);
				rem_q <= '0;
			end else begin
				rem_q <= rem_next;
			end
		end
		if (cmd.emit_load) begin
			if (sign_pend_q) begin
				symbol_q    <= SYM_MINUS;
				last_q      <= 1'b0;
				sign_pend_q <= 1'b0;
			end else begin
				symbol_q <= slot_sym(alpha, digit_q[cnt_m1[DIG_IDX_W-1:0]]);
				last_q   <= (cnt_q == DIG_CNT_W'(1));
				cnt_q    <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.alpha_ok  = chk.ok;
	assign stat.div_last  = (chunk_q == CHUNK_CW'(CHUNKS - 1));
	assign stat.quo_zero  = (mag_next == '0);
	assign stat.emit_last = !sign_pend_q && (cnt_q == DIG_CNT_W'(1));
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign last      = last_q;

endmodule

// ===== rtl/core/signed_integer_to_radix_text.sv =====
// Sequence: accept, alphabet check, long division digit by digit, then the symbols (a minus first if
// negative) at one symbol per cycle while out_ready does not stall them. The long-division unit
// consumes 8 dividend bits per cycle.
// One item is in work at a time; the final symbol may wait in the output register as the next
// item is accepted. Reset clears the controller and the output valid, and loads the alphabet
// with "0123456789" (radix ten).
module signed_integer_to_radix_text import sirt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [REG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [MAG_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SYM_W-1:0]        symbol,
	output logic                    last
);

	// Command and status groups between controller and datapath.
	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Controller: IDLE until a transfer, check alphabet (fail: back to IDLE), divide, drain symbols.
	sirt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: alphabet registers, divider, digit stack and the output register.
	sirt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.value     (value),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.symbol    (symbol),
		.last      (last)
	);

	// At most one command is issued in any cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.check, cmd.div_step, cmd.emit_load}))
		else $error("more than one datapath command active");

	// Block goes busy after an input transfer.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while an item is in work");

	// Division stops after the digit whose quotient is zero.
	a_div_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && stat.div_last && stat.quo_zero) |=> !cmd.div_step)
		else $error("division continued past the final digit");

	// A new output load never overwrites a result still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> (!out_valid || out_ready))
		else $error("output register overwritten");

endmodule
